FILE: rtl/nfcd_pkg.sv
// Package for the NOR flash command device: item types, command keys and block map.
package nfcd_pkg;

   // Array geometry
   localparam int unsigned ArrayBytes = 2097152;
   localparam int unsigned AddrW      = 21;
   localparam int unsigned DataW      = 8;

   // Busy times in ticks
   localparam logic [7:0] PROGRAM_BUSY_TICKS = 8'd33;
   localparam logic [7:0] ERASE_BUSY_TICKS   = 8'd130;

   // Command cycle keys
   localparam logic [11:0] CMD_ADDR_A  = 12'hAAA;
   localparam logic [11:0] CMD_ADDR_B  = 12'h555;
   localparam logic [7:0]  CMD_UNLOCK1 = 8'hAA;
   localparam logic [7:0]  CMD_UNLOCK2 = 8'h55;
   localparam logic [7:0]  CMD_PROGRAM = 8'hA0;
   localparam logic [7:0]  CMD_ERASE   = 8'h80;
   localparam logic [7:0]  CMD_SECTOR  = 8'h30;
   localparam logic [7:0]  ERASED_BYTE = 8'hFF;

   // Item function codes
   localparam logic FUNC_BUS  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic             func;
      logic [AddrW-1:0] address;
      logic [DataW-1:0] data_in;
      logic             chip_enable_n;
      logic             write_enable_n;
      logic             output_enable_n;
   } req_type;

   typedef struct packed {
      logic [DataW-1:0] read_data;
      logic             read_valid;
      logic             busy_res;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_ERASE
   } state_type;

   typedef struct packed {
      logic [AddrW-1:0] first;
      logic [AddrW-1:0] last;
   } block_type;

   // Program sequence: AAA/AA, 555/55, AAA/A0
   function automatic logic prog_key_match(input logic [1:0] step,
                                           input logic [11:0] addr,
                                           input logic [7:0] data);
      logic hit;
      hit = 1'b0;
      case (step)
         2'd0:    hit = (addr == CMD_ADDR_A) && (data == CMD_UNLOCK1);
         2'd1:    hit = (addr == CMD_ADDR_B) && (data == CMD_UNLOCK2);
         2'd2:    hit = (addr == CMD_ADDR_A) && (data == CMD_PROGRAM);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Erase sequence: AAA/AA, 555/55, AAA/80, AAA/AA, 555/55, any/30
   function automatic logic erase_key_match(input logic [2:0] step,
                                            input logic [11:0] addr,
                                            input logic [7:0] data);
      logic hit;
      hit = 1'b0;
      case (step)
         3'd0:    hit = (addr == CMD_ADDR_A) && (data == CMD_UNLOCK1);
         3'd1:    hit = (addr == CMD_ADDR_B) && (data == CMD_UNLOCK2);
         3'd2:    hit = (addr == CMD_ADDR_A) && (data == CMD_ERASE);
         3'd3:    hit = (addr == CMD_ADDR_A) && (data == CMD_UNLOCK1);
         3'd4:    hit = (addr == CMD_ADDR_B) && (data == CMD_UNLOCK2);
         3'd5:    hit = (data == CMD_SECTOR);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Boot-block layout: first and last byte of the block holding addr
   function automatic block_type erase_block(input logic [AddrW-1:0] addr,
                                             input logic top_boot);
      block_type blk;
      blk.first = {addr[20:16], 16'h0000};
      blk.last  = {addr[20:16], 16'hFFFF};
      if (top_boot) begin
         if (addr[20:16] == 5'h1F) begin
            if (addr[15:0] < 16'h8000) begin
               blk.first = 21'h1F0000;
               blk.last  = 21'h1F7FFF;
            end else if (addr[15:0] < 16'hA000) begin
               blk.first = 21'h1F8000;
               blk.last  = 21'h1F9FFF;
            end else if (addr[15:0] < 16'hC000) begin
               blk.first = 21'h1FA000;
               blk.last  = 21'h1FBFFF;
            end else begin
               blk.first = 21'h1FC000;
               blk.last  = 21'h1FFFFF;
            end
         end
      end else begin
         if (addr < 21'h004000) begin
            blk.first = 21'h000000;
            blk.last  = 21'h003FFF;
         end else if (addr < 21'h006000) begin
            blk.first = 21'h004000;
            blk.last  = 21'h005FFF;
         end else if (addr < 21'h008000) begin
            blk.first = 21'h006000;
            blk.last  = 21'h007FFF;
         end else if (addr < 21'h010000) begin
            blk.first = 21'h008000;
            blk.last  = 21'h00FFFF;
         end
      end
      return blk;
   endfunction

endpackage

FILE: rtl/nfcd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module nfcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/nor_flash_command_device_core.sv
// Top level of the NOR flash command device: command detectors, busy timer and array.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------
//  req_     | in        | req_valid / req_stall | nfcd_pkg::req_type
//  rsp_     | out       | rsp_valid / rsp_stall | nfcd_pkg::rsp_type
//  csr_     | in        | csr_valid / csr_ready | top_boot (1 bit)
//
// A bus or tick item is accepted in idle; the array read issued at accept is registered
// and returns in the next cycle, and the item commits once no held result blocks it. An
// erase then fills its block (8K to 64K bytes) with 0xFF while no item enters.
// After reset a clearing pass fills all 2,097,152 bytes of the array; req_stall is high.
// A result waiting on rsp_stall does not block the next accept; a second commit waits.
module nor_flash_command_device_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nfcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nfcd_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_top_boot
);

   nfcd_pkg::state_type state_ff, state_in;
   nfcd_pkg::req_type   item_ff;
   nfcd_pkg::rsp_type   rsp_ff, rsp_in;
   nfcd_pkg::block_type blk;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       top_boot_ff;
   logic [1:0]                 pcount_ff, pcount_in;
   logic [2:0]                 ecount_ff, ecount_in;
   logic                       prev_we_ff, prev_we_in;
   logic [7:0]                 busy_ff, busy_in;
   logic [nfcd_pkg::AddrW-1:0] walk_addr_ff, walk_addr_in;
   logic [nfcd_pkg::AddrW-1:0] walk_end_ff, walk_end_in;

   logic                       accept;
   logic                       commit;
   logic                       walking;
   logic                       walk_last;
   logic                       rd_en;
   logic [nfcd_pkg::DataW-1:0] rd_data;
   logic                       wr_en;
   logic [nfcd_pkg::AddrW-1:0] wr_addr;
   logic [nfcd_pkg::DataW-1:0] wr_data;

   logic                       bus_en;
   logic                       read_en;
   logic                       fall;
   logic [nfcd_pkg::DataW-1:0] lines;
   logic [2:0]                 ecount_cur;
   logic                       do_program;
   logic                       do_erase;

   // Array storage
   nfcd_ram #(
      .WIDTH (nfcd_pkg::DataW),
      .DEPTH (nfcd_pkg::ArrayBytes)
   ) u_array (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (req_payload.address),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nfcd_pkg::ST_CLEAR: begin
            if (walk_last) state_in = nfcd_pkg::ST_IDLE;
         end
         nfcd_pkg::ST_IDLE: begin
            if (req_valid) state_in = nfcd_pkg::ST_EXEC;
         end
         nfcd_pkg::ST_EXEC: begin
            if (commit) state_in = do_erase ? nfcd_pkg::ST_ERASE : nfcd_pkg::ST_IDLE;
         end
         nfcd_pkg::ST_ERASE: begin
            if (walk_last) state_in = nfcd_pkg::ST_IDLE;
         end
         default: state_in = nfcd_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      walking   = 1'b0;
      case (state_ff)
         nfcd_pkg::ST_CLEAR: walking = 1'b1;
         nfcd_pkg::ST_IDLE:  req_stall = 1'b0;
         nfcd_pkg::ST_EXEC:  req_stall = 1'b1;
         nfcd_pkg::ST_ERASE: walking = 1'b1;
         default: begin
            req_stall = 1'b1;
            walking   = 1'b0;
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign rd_en     = accept;
   assign commit    = (state_ff == nfcd_pkg::ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign walk_last = (walk_addr_ff == walk_end_ff);
   assign csr_ready = 1'b1;

   // Decode the held item against the array byte
   always_comb begin
      bus_en     = (item_ff.func == nfcd_pkg::FUNC_BUS) && !item_ff.chip_enable_n;
      read_en    = bus_en && !item_ff.output_enable_n;
      lines      = read_en ? rd_data : item_ff.data_in;
      fall       = bus_en && !item_ff.write_enable_n && prev_we_ff;
      blk        = nfcd_pkg::erase_block(item_ff.address, top_boot_ff);
      do_program = 1'b0;
      do_erase   = 1'b0;
      pcount_in  = pcount_ff;
      ecount_in  = ecount_ff;
      ecount_cur = (ecount_ff > 3'd5) ? 3'd0 : ecount_ff;
      prev_we_in = prev_we_ff;
      busy_in    = busy_ff;

      // Advance the command detectors on a falling write enable
      if (fall) begin
         if (pcount_ff == 2'd3) begin
            do_program = 1'b1;
            pcount_in  = 2'd0;
         end else if (nfcd_pkg::prog_key_match(pcount_ff, item_ff.address[11:0], lines)) begin
            pcount_in = pcount_ff + 2'd1;
         end else begin
            pcount_in = 2'd0;
         end
         if (nfcd_pkg::erase_key_match(ecount_cur, item_ff.address[11:0], lines)) begin
            if (ecount_cur == 3'd5) begin
               do_erase  = 1'b1;
               ecount_in = 3'd0;
            end else begin
               ecount_in = ecount_cur + 3'd1;
            end
         end else begin
            ecount_in = 3'd0;
         end
      end

      // Track write enable on bus items
      if (item_ff.func == nfcd_pkg::FUNC_BUS) prev_we_in = item_ff.write_enable_n;

      // Load or count down the busy timer
      if (do_erase) begin
         busy_in = nfcd_pkg::ERASE_BUSY_TICKS;
      end else if (do_program) begin
         busy_in = nfcd_pkg::PROGRAM_BUSY_TICKS;
      end else if ((item_ff.func == nfcd_pkg::FUNC_TICK) && (busy_ff != 8'd0)) begin
         busy_in = busy_ff - 8'd1;
      end

      rsp_in.read_data  = lines;
      rsp_in.read_valid = read_en;
      rsp_in.busy_res   = (busy_in != 8'd0);
   end

   // Array write: fill walker or program commit
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = walk_addr_ff;
      wr_data = nfcd_pkg::ERASED_BYTE;
      if (walking) begin
         wr_en = 1'b1;
      end else if (commit && do_program) begin
         wr_en   = 1'b1;
         wr_addr = item_ff.address;
         wr_data = rd_data & lines;
      end
   end

   // Fill walker bounds
   always_comb begin
      walk_addr_in = walk_addr_ff;
      walk_end_in  = walk_end_ff;
      if (walking && !walk_last) begin
         walk_addr_in = walk_addr_ff + {{(nfcd_pkg::AddrW-1){1'b0}}, 1'b1};
      end else if (commit && do_erase) begin
         walk_addr_in = blk.first;
         walk_end_in  = blk.last;
      end
   end

   // Output register
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || commit;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfcd_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         top_boot_ff  <= 1'b0;
         pcount_ff    <= 2'd0;
         ecount_ff    <= 3'd0;
         prev_we_ff   <= 1'b1;
         busy_ff      <= 8'd0;
         walk_addr_ff <= '0;
         walk_end_ff  <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_addr_ff <= walk_addr_in;
         walk_end_ff  <= walk_end_in;
         if (csr_valid && csr_ready) top_boot_ff <= csr_top_boot;
         if (commit) begin
            pcount_ff  <= pcount_in;
            ecount_ff  <= ecount_in;
            prev_we_ff <= prev_we_in;
            busy_ff    <= busy_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_payload;
      if (commit) rsp_ff  <= rsp_in;
   end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the NOR flash command device core.
module tb_top;

   localparam int unsigned LIMIT_CYCLES = 12000000;

   typedef struct packed {
      nfcd_pkg::req_type item;
      logic              typed;
      nfcd_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   nfcd_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   nfcd_pkg::rsp_type rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_top_boot;

   // Flash image and command state kept by the predictor
   bit [7:0]   flash_img [0:nfcd_pkg::ArrayBytes-1];
   logic [1:0] pgm_step;
   logic [2:0] ers_step;
   logic       we_last;
   logic [7:0] busy_left;
   logic       boot_top;

   nfcd_pkg::rsp_type rsp_due [$];
   nfcd_pkg::rsp_type head;
   dir_row_type       dir_tab [$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int          sent = 0;
   int          next_mix = 0;
   int          erases_left = 0;
   int          big_left = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;

   nor_flash_command_device_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_top_boot (csr_top_boot)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 50) $display("tb: %s", msg);
   endtask

   task automatic add_row(input dir_row_type r);
      dir_tab.insert(dir_tab.size(), r);
   endtask

   task automatic flash_model_reset();
      for (int k = 0; k < nfcd_pkg::ArrayBytes; k++) flash_img[k] = nfcd_pkg::ERASED_BYTE;
      pgm_step  = '0;
      ers_step  = '0;
      we_last   = 1'b1;
      busy_left = '0;
      boot_top  = 1'b0;
   endtask

   // Does one command cycle match step of the program or the erase unlock sequence?
   function automatic logic unlock_hit(input logic erase_seq, input int step,
                                       input logic [20:0] a, input logic [7:0] d);
      logic [11:0] want_a;
      logic [7:0]  want_d;
      logic        any_a;
      any_a  = 1'b0;
      want_a = nfcd_pkg::CMD_ADDR_A;
      want_d = nfcd_pkg::CMD_UNLOCK1;
      case (step)
         1, 4: begin
            want_a = nfcd_pkg::CMD_ADDR_B;
            want_d = nfcd_pkg::CMD_UNLOCK2;
         end
         2: want_d = erase_seq ? nfcd_pkg::CMD_ERASE : nfcd_pkg::CMD_PROGRAM;
         5: begin
            any_a  = 1'b1;
            want_d = nfcd_pkg::CMD_SECTOR;
         end
         default: ;
      endcase
      return (any_a || a[11:0] == want_a) && d == want_d;
   endfunction

   // Fill the boot-block-layout block that holds a
   task automatic erase_fill(input logic [20:0] a);
      int unsigned first;
      int unsigned span;
      first = 32'({a[20:16], 16'h0000});
      span  = 65536;
      if (boot_top) begin
         if (a >= 21'h1FC000) begin
            first = 'h1FC000;
            span  = 16384;
         end else if (a >= 21'h1FA000) begin
            first = 'h1FA000;
            span  = 8192;
         end else if (a >= 21'h1F8000) begin
            first = 'h1F8000;
            span  = 8192;
         end else if (a >= 21'h1F0000) begin
            span  = 32768;
         end
      end else begin
         if (a < 21'h004000) begin
            first = 0;
            span  = 16384;
         end else if (a < 21'h006000) begin
            first = 'h004000;
            span  = 8192;
         end else if (a < 21'h008000) begin
            first = 'h006000;
            span  = 8192;
         end else if (a < 21'h010000) begin
            first = 'h008000;
            span  = 32768;
         end
      end
      for (int unsigned k = first; k < first + span; k++)
         flash_img[k] = nfcd_pkg::ERASED_BYTE;
      busy_left = nfcd_pkg::ERASE_BUSY_TICKS;
   endtask

   // Advance both detectors on a falling write enable
   task automatic command_cycle(input logic [20:0] a, input logic [7:0] d);
      logic do_pgm;
      logic do_ers;
      do_pgm = 1'b0;
      do_ers = 1'b0;
      if (pgm_step == 2'd3) begin
         do_pgm   = 1'b1;
         pgm_step = '0;
      end else if (unlock_hit(1'b0, int'(pgm_step), a, d)) begin
         pgm_step = pgm_step + 2'd1;
      end else begin
         pgm_step = '0;
      end
      if (!unlock_hit(1'b1, int'(ers_step), a, d)) begin
         ers_step = '0;
      end else if (ers_step == 3'd5) begin
         do_ers   = 1'b1;
         ers_step = '0;
      end else begin
         ers_step = ers_step + 3'd1;
      end
      if (do_pgm) begin
         flash_img[a] = flash_img[a] & d;
         busy_left    = nfcd_pkg::PROGRAM_BUSY_TICKS;
      end
      if (do_ers) erase_fill(a);
   endtask

   task automatic flash_predict(input nfcd_pkg::req_type r, output nfcd_pkg::rsp_type res);
      logic [7:0] lines;
      logic       rv;
      lines = r.data_in;
      rv    = 1'b0;
      if (r.func == nfcd_pkg::FUNC_TICK) begin
         if (busy_left != 0) busy_left = busy_left - 8'd1;
      end else if (r.chip_enable_n) begin
         we_last = r.write_enable_n;
      end else begin
         if (!r.output_enable_n) begin
            lines = flash_img[r.address];
            rv    = 1'b1;
         end
         if (!r.write_enable_n && we_last) command_cycle(r.address, lines);
         we_last = r.write_enable_n;
      end
      res.read_data  = lines;
      res.read_valid = rv;
      res.busy_res   = (busy_left != 0);
   endtask

   function automatic nfcd_pkg::req_type bus(input logic [20:0] a, input logic [7:0] d,
                                             input logic ce_n, input logic we_n,
                                             input logic oe_n);
      nfcd_pkg::req_type r;
      r.func            = nfcd_pkg::FUNC_BUS;
      r.address         = a;
      r.data_in         = d;
      r.chip_enable_n   = ce_n;
      r.write_enable_n  = we_n;
      r.output_enable_n = oe_n;
      return r;
   endfunction

   function automatic nfcd_pkg::req_type tick(input logic [7:0] d);
      nfcd_pkg::req_type r;
      r      = bus('0, d, 1'b1, 1'b1, 1'b1);
      r.func = nfcd_pkg::FUNC_TICK;
      return r;
   endfunction

   function automatic dir_row_type chk(input nfcd_pkg::req_type r,
                                       input nfcd_pkg::rsp_type w);
      return {r, 1'b1, w};
   endfunction

   function automatic dir_row_type pred(input nfcd_pkg::req_type r);
      return {r, 1'b0, 10'b0};
   endfunction

   // Addresses cluster on the small blocks so reads see programs and erases
   function automatic logic [20:0] pick_addr();
      logic [20:0] base;
      if ($urandom_range(0, 3) > 1) return 21'($urandom);
      case ($urandom_range(0, 5))
         0:       base = 21'h000000;
         1:       base = 21'h004000;
         2:       base = 21'h006000;
         3:       base = 21'h1F8000;
         4:       base = 21'h1FA000;
         default: base = 21'h1FC000;
      endcase
      return base + 21'($urandom_range(0, 31));
   endfunction

   // Mostly 8K blocks, a few larger ones, rarely a full 64K block
   function automatic logic [20:0] pick_erase_addr();
      int r;
      r = $urandom_range(0, 9);
      if (r == 9 && big_left > 0) begin
         big_left--;
         return 21'($urandom);
      end
      if (r == 8) return boot_top ? 21'h1F0000 + 21'($urandom_range(0, 32767))
                                  : 21'h008000 + 21'($urandom_range(0, 32767));
      if (r == 7) return boot_top ? 21'h1FC000 + 21'($urandom_range(0, 16383))
                                  : 21'($urandom_range(0, 16383));
      if (boot_top) return ($urandom_range(0, 1) ? 21'h1F8000 : 21'h1FA000)
                           + 21'($urandom_range(0, 8191));
      return ($urandom_range(0, 1) ? 21'h004000 : 21'h006000)
             + 21'($urandom_range(0, 8191));
   endfunction

   // Hand one item to the block, then record what it should return
   task automatic send(input nfcd_pkg::req_type r, input logic typed,
                       input nfcd_pkg::rsp_type want);
      nfcd_pkg::rsp_type calc;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      flash_predict(r, calc);
      rsp_due.insert(rsp_due.size(), typed ? want : calc);
      sent++;
   endtask

   // Write cycle followed by a random release that raises write enable again
   task automatic cmd_write(input logic [20:0] a, input logic [7:0] d, input logic oe_n);
      send(bus(a, d, 1'b0, 1'b0, oe_n), 1'b0, '0);
      send(bus(pick_addr(), 8'($urandom), $urandom_range(0, 3) == 0, 1'b1,
               1'($urandom_range(0, 1))), 1'b0, '0);
   endtask

   // Program unlock plus data cycle; a step at cut gets one data bit flipped
   task automatic program_seq(input int cut);
      logic [20:0] a;
      logic [7:0]  d;
      int          b;
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: begin
               a = {9'($urandom), nfcd_pkg::CMD_ADDR_A};
               d = nfcd_pkg::CMD_UNLOCK1;
            end
            1: begin
               a = {9'($urandom), nfcd_pkg::CMD_ADDR_B};
               d = nfcd_pkg::CMD_UNLOCK2;
            end
            2: begin
               a = {9'($urandom), nfcd_pkg::CMD_ADDR_A};
               d = nfcd_pkg::CMD_PROGRAM;
            end
            default: begin
               a = pick_addr();
               d = 8'($urandom);
            end
         endcase
         if (i == cut) begin
            b    = $urandom_range(0, 7);
            d[b] = ~d[b];
         end
         cmd_write(a, d, (i == 3 && $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1);
      end
   endtask

   task automatic erase_seq(input int cut);
      logic [20:0] a;
      logic [7:0]  d;
      int          b;
      for (int i = 0; i < 6; i++) begin
         a = {9'($urandom), (i == 1 || i == 4) ? nfcd_pkg::CMD_ADDR_B
                                               : nfcd_pkg::CMD_ADDR_A};
         case (i)
            0, 3:    d = nfcd_pkg::CMD_UNLOCK1;
            1, 4:    d = nfcd_pkg::CMD_UNLOCK2;
            2:       d = nfcd_pkg::CMD_ERASE;
            default: begin
               d = nfcd_pkg::CMD_SECTOR;
               a = (cut < 0) ? pick_erase_addr() : pick_addr();
            end
         endcase
         if (i == cut) begin
            b    = $urandom_range(0, 7);
            d[b] = ~d[b];
         end
         cmd_write(a, d, 1'b1);
      end
   endtask

   function automatic nfcd_pkg::req_type rand_req();
      nfcd_pkg::req_type r;
      r.func            = 1'($urandom_range(0, 1));
      r.address         = 21'($urandom);
      r.data_in         = 8'($urandom);
      r.chip_enable_n   = 1'($urandom_range(0, 1));
      r.write_enable_n  = 1'($urandom_range(0, 1));
      r.output_enable_n = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Random mix of well-formed commands, broken ones, reads, ticks and noise
   task automatic run_phase(input int n_items, input bit idle_ok);
      int                stop;
      int                kind;
      int                n;
      nfcd_pkg::req_type r;
      stop        = sent + n_items;
      next_mix    = sent;
      erases_left = 8;
      big_left    = 1;
      while (sent < stop) begin
         if (sent >= next_mix) begin
            idle_on  = idle_ok && $urandom_range(0, 3) != 0;
            next_mix = sent + $urandom_range(40, 120);
         end
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            program_seq(-1);
         end else if (kind < 46) begin
            if (erases_left > 0) begin
               erases_left--;
               erase_seq(-1);
            end else begin
               program_seq(-1);
            end
         end else if (kind < 56) begin
            if ($urandom_range(0, 1)) program_seq($urandom_range(0, 2));
            else erase_seq($urandom_range(0, 5));
         end else if (kind < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 12);
            repeat (n) begin
               r      = rand_req();
               r.func = nfcd_pkg::FUNC_TICK;
               send(r, 1'b0, '0);
            end
         end else if (kind < 86) begin
            repeat ($urandom_range(1, 6))
               send(bus(pick_addr(), 8'($urandom), 1'b0, 1'b1, 1'b0), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 4)) send(rand_req(), 1'b0, '0);
         end
      end
   endtask

   // Let every expected item come back before touching the register
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic v);
      @(negedge clock);
      csr_valid    <= 1'b1;
      csr_top_boot <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      boot_top = v;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Receiver stall bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each returned item against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            report($sformatf("unexpected item read_data=%h", rsp_payload.read_data));
         end else begin
            head = rsp_due.pop_front();
            if (rsp_payload.read_data !== head.read_data)
               report($sformatf("read_data %h, want %h", rsp_payload.read_data,
                                head.read_data));
            if (rsp_payload.read_valid !== head.read_valid)
               report($sformatf("read_valid %b, want %b", rsp_payload.read_valid,
                                head.read_valid));
            if (rsp_payload.busy_res !== head.busy_res)
               report($sformatf("busy_res %b, want %b", rsp_payload.busy_res,
                                head.busy_res));
         end
      end
   end

   initial begin
      dir_row_type row;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_top_boot = 1'b0;
      flash_model_reset();
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      csr_write(1'b0);

      // Reads at both ends, a tick, then chip disabled with write enable held low
      add_row(chk(bus(21'h000000, 8'h00, 1'b0, 1'b1, 1'b0), {nfcd_pkg::ERASED_BYTE, 2'b10}));
      add_row(chk(bus(21'h1FFFFF, 8'hFF, 1'b0, 1'b1, 1'b0), {nfcd_pkg::ERASED_BYTE, 2'b10}));
      add_row(chk(tick(8'hA5), {8'hA5, 2'b00}));
      add_row(chk(bus(21'h1FFFFF, 8'h00, 1'b1, 1'b0, 1'b0), {8'h00, 2'b00}));
      // No falling edge here: write enable was already low
      add_row(chk(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1),
                  {nfcd_pkg::CMD_UNLOCK1, 2'b00}));
      // Repeated first unlock restarts without retrying; data cycle must not program
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_B}, nfcd_pkg::CMD_UNLOCK2, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_PROGRAM, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus(21'h004001, 8'h00, 1'b0, 1'b0, 1'b1)));
      add_row(chk(bus(21'h004001, 8'h00, 1'b0, 1'b1, 1'b0), {nfcd_pkg::ERASED_BYTE, 2'b10}));
      // Program with upper address bits set, then read back while busy
      add_row(pred(bus({9'h1FF, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h0AB, nfcd_pkg::CMD_ADDR_B}, nfcd_pkg::CMD_UNLOCK2, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h155, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_PROGRAM, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus(21'h004001, 8'h3C, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus(21'h004001, 8'h00, 1'b0, 1'b1, 1'b0)));
      // Program again while busy, data cycle with output enable low sees the array byte
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_B}, nfcd_pkg::CMD_UNLOCK2, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_PROGRAM, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus(21'h004001, 8'h00, 1'b0, 1'b0, 1'b0)));
      // Sector erase of the 8K block at 0x4000
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_B}, nfcd_pkg::CMD_UNLOCK2, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_ERASE, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_A}, nfcd_pkg::CMD_UNLOCK1, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus({9'h000, nfcd_pkg::CMD_ADDR_B}, nfcd_pkg::CMD_UNLOCK2, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus(21'h005000, nfcd_pkg::CMD_SECTOR, 1'b0, 1'b0, 1'b1)));
      add_row(pred(bus(21'h004001, 8'h00, 1'b0, 1'b1, 1'b0)));
      add_row(pred(tick(8'h00)));

      // Walk the table; each enabled write cycle is followed by a release
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         send(row.item, row.typed, row.want);
         if (row.item.func == nfcd_pkg::FUNC_BUS && !row.item.chip_enable_n &&
             !row.item.write_enable_n)
            send(bus(row.item.address, row.item.data_in, 1'b0, 1'b1, 1'b1), 1'b0, '0);
      end

      drain();
      csr_write(1'b1);
      run_phase(410, 1'b1);
      drain();
      csr_write(1'b0);
      run_phase(410, 1'b1);
      drain();
      csr_write(1'b1);
      run_phase(400, 1'b1);
      drain();
      csr_write(1'b0);
      run_phase(400, 1'b0);
      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: nor_flash_command_device_core.f
rtl/nfcd_pkg.sv
rtl/nfcd_ram.sv
rtl/nor_flash_command_device_core.sv
verif/tb_top.sv
